// ===== rtl/mpbm_pkg.sv =====
`default_nettype none
package mpbm_pkg;

    // Automaton size
    localparam int NUM_STATES = 1024;
    localparam int ALPHABET   = 256;

    // Fixed field widths of the item ports
    localparam int ENTRY_W  = 10;
    localparam int SYMBOL_W = 8;

    // Derived widths
    localparam int STATE_W    = $clog2(NUM_STATES);
    localparam int SYM_W      = $clog2(ALPHABET);
    localparam int GOTO_W     = STATE_W + 1;
    localparam int GOTO_AW    = STATE_W + SYM_W;
    localparam int GOTO_DEPTH = NUM_STATES * ALPHABET;
    localparam int HOP_W      = $clog2(NUM_STATES + 1);

    localparam logic [HOP_W-1:0]   HOP_MAX    = HOP_W'(NUM_STATES);
    localparam logic [STATE_W-1:0] ROOT_STATE = '0;

    // ASCII case folding
    localparam logic [SYMBOL_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [SYMBOL_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [SYMBOL_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        ACT_SCAN  = 2'd0,
        ACT_GOTO  = 2'd1,
        ACT_FAIL  = 2'd2,
        ACT_MATCH = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GOTO,
        ST_FAIL,
        ST_MATCH
    } t_walk_state;

    // Table read requests from the walker
    typedef struct packed {
        logic               goto_rd;
        logic [GOTO_AW-1:0] goto_addr;
        logic               fail_rd;
        logic [STATE_W-1:0] fail_addr;
        logic               match_rd;
        logic [STATE_W-1:0] match_addr;
    } t_rd_req;

endpackage
`default_nettype wire

// ===== rtl/multi_pattern_byte_matcher.sv =====
// Channel  Handshake                     Payload
// in       i_in_valid / o_in_stall       i_action, i_restart, i_symbol, i_entry_state,
//                                        i_entry_value, i_entry_defined
// out      o_out_valid / i_out_stall     o_current_state, o_matched, o_found
// cfg      i_cfg_valid / o_cfg_ready     i_cfg_data (fold_case)
//
// A scan beat holds the walker through goto read, match read and load; the result
// register is loaded as the walker leaves the load step and returns to idle, where
// it takes the next beat. Each failure hop adds a fail read and a goto read.
// Reset is synchronous, active low; it clears scan state, found and fold_case
// but not the tables. A full result register holds the walker in its last step.
`default_nettype none
module multi_pattern_byte_matcher import mpbm_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input item channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_action,
    input  wire logic                i_restart,
    input  wire logic [SYMBOL_W-1:0] i_symbol,
    input  wire logic [ENTRY_W-1:0]  i_entry_state,
    input  wire logic [ENTRY_W-1:0]  i_entry_value,
    input  wire logic                i_entry_defined,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [ENTRY_W-1:0]       o_current_state,
    output logic                     o_matched,
    output logic                     o_found,
    // configuration
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_data
);

    logic               r_fold_case;
    logic               in_accept;
    t_action            action;
    logic               is_scan;
    logic               entry_ok;
    logic               sym_ok;
    logic               goto_wr;
    logic               fail_wr;
    logic               match_wr;
    logic [SYMBOL_W-1:0] folded;
    logic               busy;
    t_rd_req            req;
    logic [GOTO_W-1:0]  goto_rd_data;
    logic [STATE_W-1:0] fail_rd_data;
    logic               match_rd_data;
    logic [STATE_W-1:0] out_state;

    // config register: always ready; the user must write it only while idle, the block does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fold_case <= i_cfg_data;
        end
    end

    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign action     = t_action'(i_action);
    assign is_scan    = (action == ACT_SCAN);

    // writes outside the tables are dropped
    assign entry_ok = (32'(i_entry_state) < NUM_STATES);
    assign sym_ok   = (32'(i_symbol) < ALPHABET);
    assign goto_wr  = in_accept && action == ACT_GOTO && entry_ok && sym_ok;
    assign fail_wr  = in_accept && action == ACT_FAIL && entry_ok;
    assign match_wr = in_accept && action == ACT_MATCH && entry_ok;

    // ASCII upper case to lower case when folding is on
    always_comb begin
        folded = i_symbol;
        if (r_fold_case && i_symbol >= CH_UPPER_A && i_symbol <= CH_UPPER_Z) begin
            folded = i_symbol + CASE_OFFSET;
        end
    end

    // goto entries: {defined, next state}, addressed by {state, symbol}
    mpbm_ram #(
        .WIDTH (GOTO_W),
        .DEPTH (GOTO_DEPTH)
    ) u_goto_ram (
        .i_clk     (i_clk),
        .i_wr_en   (goto_wr),
        .i_wr_addr ({i_entry_state[STATE_W-1:0], i_symbol[SYM_W-1:0]}),
        .i_wr_data ({i_entry_defined, i_entry_value[STATE_W-1:0]}),
        .i_rd_en   (req.goto_rd),
        .i_rd_addr (req.goto_addr),
        .o_rd_data (goto_rd_data)
    );

    mpbm_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_STATES)
    ) u_fail_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fail_wr),
        .i_wr_addr (i_entry_state[STATE_W-1:0]),
        .i_wr_data (i_entry_value[STATE_W-1:0]),
        .i_rd_en   (req.fail_rd),
        .i_rd_addr (req.fail_addr),
        .o_rd_data (fail_rd_data)
    );

    // match flags already fold in matches inherited along failure links
    mpbm_ram #(
        .WIDTH (1),
        .DEPTH (NUM_STATES)
    ) u_match_ram (
        .i_clk     (i_clk),
        .i_wr_en   (match_wr),
        .i_wr_addr (i_entry_state[STATE_W-1:0]),
        .i_wr_data (i_entry_value[0]),
        .i_rd_en   (req.match_rd),
        .i_rd_addr (req.match_addr),
        .o_rd_data (match_rd_data)
    );

    mpbm_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_accept && is_scan),
        .i_restart     (i_restart),
        .i_sym         (folded[SYM_W-1:0]),
        .i_goto_data   (goto_rd_data),
        .i_fail_data   (fail_rd_data),
        .i_match_data  (match_rd_data),
        .i_out_stall   (i_out_stall),
        .o_busy        (busy),
        .o_req         (req),
        .o_out_valid   (o_out_valid),
        .o_out_state   (out_state),
        .o_out_matched (o_matched),
        .o_out_found   (o_found)
    );

    assign o_current_state = ENTRY_W'(out_state);

endmodule
`default_nettype wire

// ===== rtl/mpbm_ram.sv =====
`default_nettype none
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/mpbm_walk.sv =====
`default_nettype none
module mpbm_walk import mpbm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_restart,
    input  wire logic [SYM_W-1:0]   i_sym,
    input  wire logic [GOTO_W-1:0]  i_goto_data,
    input  wire logic [STATE_W-1:0] i_fail_data,
    input  wire logic               i_match_data,
    input  wire logic               i_out_stall,
    output logic                    o_busy,
    output t_rd_req                 o_req,
    output logic                    o_out_valid,
    output logic [STATE_W-1:0]      o_out_state,
    output logic                    o_out_matched,
    output logic                    o_out_found
);

    t_walk_state        r_st, n_st;
    logic [STATE_W-1:0] r_scan, n_scan;
    logic               r_found, n_found;
    logic [STATE_W-1:0] r_cur, n_cur;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [HOP_W-1:0]   r_hops, n_hops;
    logic [STATE_W-1:0] r_next, n_next;
    logic               r_out_valid, n_out_valid;
    logic [STATE_W-1:0] r_out_state, n_out_state;
    logic               r_out_matched, n_out_matched;
    logic               r_out_found, n_out_found;

    logic               out_free;
    logic [STATE_W-1:0] start_state;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign start_state = i_restart ? ROOT_STATE : r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_scan      <= ROOT_STATE;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_scan      <= n_scan;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_cur         <= n_cur;
        r_sym         <= n_sym;
        r_hops        <= n_hops;
        r_next        <= n_next;
        r_out_state   <= n_out_state;
        r_out_matched <= n_out_matched;
        r_out_found   <= n_out_found;
    end

    always_comb begin
        n_st          = r_st;
        n_scan        = r_scan;
        n_found       = r_found;
        n_cur         = r_cur;
        n_sym         = r_sym;
        n_hops        = r_hops;
        n_next        = r_next;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_state   = r_out_state;
        n_out_matched = r_out_matched;
        n_out_found   = r_out_found;
        o_req         = '0;

        case (r_st)
            ST_IDLE: begin
                if (i_start) begin
                    n_cur           = start_state;
                    n_sym           = i_sym;
                    n_hops          = '0;
                    if (i_restart) begin
                        n_found = 1'b0;
                    end
                    o_req.goto_rd   = 1'b1;
                    o_req.goto_addr = {start_state, i_sym};
                    n_st            = ST_GOTO;
                end
            end
            ST_GOTO: begin
                if (i_goto_data[STATE_W]) begin
                    n_next           = i_goto_data[STATE_W-1:0];
                    o_req.match_rd   = 1'b1;
                    o_req.match_addr = i_goto_data[STATE_W-1:0];
                    n_st             = ST_MATCH;
                end else if (r_cur == ROOT_STATE || r_hops == HOP_MAX) begin
                    // dead end at root or runaway chain: fall back to root
                    n_next           = ROOT_STATE;
                    o_req.match_rd   = 1'b1;
                    o_req.match_addr = ROOT_STATE;
                    n_st             = ST_MATCH;
                end else begin
                    o_req.fail_rd    = 1'b1;
                    o_req.fail_addr  = r_cur;
                    n_st             = ST_FAIL;
                end
            end
            ST_FAIL: begin
                n_cur           = i_fail_data;
                n_hops          = r_hops + HOP_W'(1);
                o_req.goto_rd   = 1'b1;
                o_req.goto_addr = {i_fail_data, r_sym};
                n_st            = ST_GOTO;
            end
            ST_MATCH: begin
                // match RAM data holds until the result register frees up
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_state   = r_next;
                    n_out_matched = i_match_data;
                    n_out_found   = r_found | i_match_data;
                    n_scan        = r_next;
                    n_found       = r_found | i_match_data;
                    n_st          = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_st != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_state   = r_out_state;
    assign o_out_matched = r_out_matched;
    assign o_out_found   = r_out_found;

endmodule
`default_nettype wire
